>>> design/exposure_timer_with_lag_and_beep_macros.svh
// Assertion macros shared by the exposure timer RTL.
`ifndef EXPOSURE_TIMER_WITH_LAG_AND_BEEP_MACROS_SVH
`define EXPOSURE_TIMER_WITH_LAG_AND_BEEP_MACROS_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define ETLB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("exposure timer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ETLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("exposure timer check failed");

`else

`define ETLB_ASSERT_SAME(label, clk, rst, ante, cons)
`define ETLB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/etlb_pkg.sv
// Types and constants of the exposure timer.
`default_nettype none

package etlb_pkg;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_PAUSE  = 3'd2,
      OP_RESUME = 3'd3,
      OP_STOP   = 3'd4,
      OP_RESET  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_STOPPED = 2'd0,
      ST_RUNNING = 2'd1,
      ST_PAUSED  = 2'd2
   } status_type;

   localparam logic CSR_LAG_MS      = 1'b0;
   localparam logic CSR_BEEP_VOLUME = 1'b1;

   localparam logic [7:0] BEEP_VOLUME_RESET = 8'd128;

   localparam int unsigned BEEP_WINDOW_MS     = 100;
   localparam int unsigned BEEP_SLOT_MS       = 100;
   localparam int unsigned BEEP_MIN_SLOTS     = 5;
   localparam int unsigned BEEP_SLOTS_PER_SEC = 10;
   localparam int unsigned BEEP_SEC_MS        = BEEP_SLOT_MS * BEEP_SLOTS_PER_SEC;

   // Reciprocal of one second in milliseconds, exact floor division for 32-bit values.
   localparam int unsigned   SEC_RECIP_SHIFT = 41;
   localparam longint        SEC_RECIP_WIDE  =
      ((64'd1 << SEC_RECIP_SHIFT) + 64'(BEEP_SEC_MS) - 64'd1) / 64'(BEEP_SEC_MS);
   localparam logic [31:0]   SEC_RECIP       = SEC_RECIP_WIDE[31:0];

   typedef struct packed {
      logic [31:0] duration_ms;
      logic [31:0] now_ms;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] last_run_ms;
      logic [31:0] total_ms;
      logic [31:0] left_ms;
      logic        in_lag;
      logic        pause_counted;
      logic        just_stopped;
      logic [7:0]  beep_level;
      logic        lamp_on;
      status_type  status;
   } rsp_data_type;

endpackage

`default_nettype wire

>>> design/exposure_timer_with_lag_and_beep.sv
// Top level of the exposure timer: command decode, timer state and result register.
`default_nettype none
`include "exposure_timer_with_lag_and_beep_macros.svh"

// Exposure timer with lamp warm-up lag and beeper. Every item is one command
// (tick, start, pause, resume, stop, reset) and yields exactly one result item
// with the state after that command. An accepted item sits in an input register
// and is folded into the timer state in one pass of logic that writes the result
// register, so one item is taken in every clock cycle unless the result register is
// held by a stalled receiver; the rate is set by the state update, whose longest
// path runs through the elapsed-time subtract and the constant multiply that finds
// the position within the current second. Configuration writes are always taken
// and are meant to arrive only while no item is in flight.
module exposure_timer_with_lag_and_beep (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Configuration write channel.
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [15:0]                  csr_data,
   // Command items.
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire etlb_pkg::req_data_type       req_tdata,  // now_ms, duration_ms
   input  wire logic [2:0]                   req_tuser,  // op
   // Result items.
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // status, lamp_on, beep_level, just_stopped, pause_counted, in_lag,
   // left_ms, total_ms, last_run_ms, zero fill
   output etlb_pkg::rsp_data_type            rsp_tdata
);
   import etlb_pkg::*;

   // Input register.
   logic         in_valid_ff;
   op_type       in_op_ff;
   logic [31:0]  in_now_ff;
   logic [31:0]  in_dur_ff;
   logic         advance;

   // Configuration and timer state.
   logic [15:0]  lag_ff;
   logic [7:0]   volume_ff;
   status_type   status_ff, status_in;
   logic [31:0]  clock_ff, clock_in;
   logic [31:0]  stamp_ff, stamp_in;
   logic [31:0]  remain_ff, remain_in;
   logic [31:0]  accum_ff, accum_in;
   logic [31:0]  last_run_ff, last_run_in;
   logic         beep_ff, beep_in;

   // Result register.
   logic         rsp_valid_ff;
   rsp_data_type rsp_ff, rsp_in;

   // Shared arithmetic on the current state.
   logic [31:0]  clk_cur;
   logic [31:0]  lag_wide;
   logic [31:0]  elapsed;
   logic         running;
   logic [31:0]  counted;
   logic [31:0]  stop_instant;
   logic         timed_out;
   logic [31:0]  accum_plus_counted;
   logic [31:0]  accum_plus_remain;
   logic [63:0]  sec_product;
   logic [22:0]  whole_secs;
   logic [31:0]  sec_base;
   logic [31:0]  sec_offset;
   logic         beep_tick;

   // Control results of the command decode.
   logic         just_stopped_c;
   logic         pause_counted_c;
   logic         restart_c;
   logic [31:0]  counted_new;
   logic         run_new;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // A tick acts on the clock value it carries; every other command on the latched one.
   assign clk_cur      = (in_op_ff == OP_TICK) ? in_now_ff : clock_ff;
   assign lag_wide     = {16'd0, lag_ff};
   assign running      = (status_ff == ST_RUNNING);
   assign elapsed      = clk_cur - stamp_ff;
   assign counted      = (running && elapsed >= lag_wide) ? elapsed - lag_wide : 32'd0;
   assign stop_instant = stamp_ff + remain_ff + lag_wide;
   assign timed_out    = clk_cur >= stop_instant;

   assign accum_plus_counted = sat_add(accum_ff, counted);
   assign accum_plus_remain  = sat_add(accum_ff, remain_ff);

   // Position of the counted time within its second. With the minimum slot count
   // below one second, "more than the minimum slots and on a whole second" is the
   // same as "at least one second in and within the first slot of that second".
   assign sec_product = 64'(counted) * 64'(SEC_RECIP);
   assign whole_secs  = sec_product[SEC_RECIP_SHIFT +: 23];
   assign sec_base    = 32'(whole_secs) * 32'(BEEP_SEC_MS);
   assign sec_offset  = counted - sec_base;
   assign beep_tick   = (elapsed <= 32'(BEEP_WINDOW_MS)) ||
                        (counted >= 32'(BEEP_SEC_MS) &&
                         BEEP_MIN_SLOTS < BEEP_SLOTS_PER_SEC &&
                         sec_offset < 32'(BEEP_SLOT_MS));

   // Next timer state.
   always_comb begin
      status_in       = status_ff;
      clock_in        = clock_ff;
      stamp_in        = stamp_ff;
      remain_in       = remain_ff;
      accum_in        = accum_ff;
      last_run_in     = last_run_ff;
      beep_in         = beep_ff;
      just_stopped_c  = 1'b0;
      pause_counted_c = 1'b0;
      restart_c       = 1'b0;
      case (in_op_ff)
         OP_TICK: begin
            clock_in = in_now_ff;
            if (running) begin
               if (counted != 32'd0) begin
                  last_run_in = counted;
               end
               if (timed_out) begin
                  just_stopped_c = 1'b1;
                  beep_in        = 1'b0;
                  accum_in       = accum_plus_remain;
                  remain_in      = 32'd0;
                  status_in      = ST_STOPPED;
               end else begin
                  beep_in = beep_tick;
               end
            end
         end
         OP_START: begin
            remain_in = in_dur_ff;
            stamp_in  = clock_ff;
            status_in = ST_RUNNING;
            restart_c = 1'b1;
         end
         OP_PAUSE: begin
            if (running) begin
               beep_in = 1'b0;
               if (counted != 32'd0) begin
                  last_run_in = counted;
               end
               accum_in        = accum_plus_counted;
               remain_in       = (counted > remain_ff) ? 32'd0 : remain_ff - counted;
               pause_counted_c = clock_ff > (stamp_ff + lag_wide);
               status_in       = ST_PAUSED;
            end
         end
         OP_RESUME: begin
            if (status_ff == ST_PAUSED) begin
               stamp_in  = clock_ff;
               status_in = ST_RUNNING;
               restart_c = 1'b1;
            end
         end
         OP_STOP, OP_RESET: begin
            if (status_ff != ST_STOPPED) begin
               beep_in = 1'b0;
               if (counted != 32'd0) begin
                  last_run_in = counted;
               end
               if (running) begin
                  accum_in = timed_out ? accum_plus_remain : accum_plus_counted;
               end
               remain_in = 32'd0;
               status_in = ST_STOPPED;
            end
            if (in_op_ff == OP_RESET) begin
               accum_in    = 32'd0;
               last_run_in = 32'd0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result of the item. While the run continues from the same resume point the
   // counted time, stop instant and clock are those already computed above.
   assign run_new     = (status_in == ST_RUNNING);
   assign counted_new = (run_new && !restart_c) ? counted : 32'd0;

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = status_in;
      rsp_in.lamp_on       = run_new;
      rsp_in.beep_level    = beep_in ? volume_ff : 8'd0;
      rsp_in.just_stopped  = just_stopped_c;
      rsp_in.pause_counted = pause_counted_c;
      rsp_in.in_lag        = run_new && (counted_new == 32'd0);
      rsp_in.left_ms       = (counted_new != 32'd0) ? stop_instant - clk_cur : remain_in;
      rsp_in.total_ms      = (counted_new != 32'd0) ? accum_plus_counted : accum_in;
      rsp_in.last_run_ms   = last_run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lag_ff       <= 16'd0;
         volume_ff    <= BEEP_VOLUME_RESET;
         status_ff    <= ST_STOPPED;
         clock_ff     <= 32'd0;
         stamp_ff     <= 32'd0;
         remain_ff    <= 32'd0;
         accum_ff     <= 32'd0;
         last_run_ff  <= 32'd0;
         beep_ff      <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LAG_MS:      lag_ff    <= csr_data;
               CSR_BEEP_VOLUME: volume_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            status_ff   <= status_in;
            clock_ff    <= clock_in;
            stamp_ff    <= stamp_in;
            remain_ff   <= remain_in;
            accum_ff    <= accum_in;
            last_run_ff <= last_run_in;
            beep_ff     <= beep_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= op_type'(req_tuser);
         in_now_ff <= req_tdata.now_ms;
         in_dur_ff <= req_tdata.duration_ms;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `ETLB_ASSERT_SAME(a_beep_only_running, clock, reset, status_ff != ST_RUNNING, !beep_ff)
   `ETLB_ASSERT_SAME(a_stopped_no_remain, clock, reset, status_ff == ST_STOPPED, remain_ff == 32'd0)
   `ETLB_ASSERT_SAME(a_lamp_follows_status, clock, reset, rsp_valid_ff, rsp_ff.lamp_on == (rsp_ff.status == ST_RUNNING))
   `ETLB_ASSERT_SAME(a_timeout_stops, clock, reset, rsp_valid_ff && rsp_ff.just_stopped, rsp_ff.status == ST_STOPPED && rsp_ff.left_ms == 32'd0)
   `ETLB_ASSERT_NEXT(a_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule

`default_nettype wire

>>> sim/exposure_timer_with_lag_and_beep_test.sv
// Self-checking testbench of the exposure timer: command stimulus, result prediction and checks.
`timescale 1ns / 100ps

module exposure_timer_with_lag_and_beep_test;
   import etlb_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_REPORTS  = 10;
   // Op codes that the block does not define; they must leave the state alone.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // Tracks the timer state from accepted commands and holds the results they are due to give.
   class exposure_tracker;
      logic [15:0]  lag;
      logic [7:0]   volume;
      status_type   run_st;
      logic [31:0]  clk_now;
      logic [31:0]  resume_at;
      logic [31:0]  remain;
      logic [31:0]  accum;
      logic [31:0]  last_run;
      bit           beep_on;
      rsp_data_type due_results[$];
      int           errors;
      int           items;
      int           results;
      int           timeouts;
      int           beeps;

      function new();
         lag       = '0;
         volume    = BEEP_VOLUME_RESET;
         run_st    = ST_STOPPED;
         clk_now   = '0;
         resume_at = '0;
         remain    = '0;
         accum     = '0;
         last_run  = '0;
         beep_on   = 1'b0;
         errors    = 0;
         items     = 0;
         results   = 0;
         timeouts  = 0;
         beeps     = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] value);
         if (idx == CSR_LAG_MS) begin
            lag = value;
         end else begin
            volume = value[7:0];
         end
      endfunction

      function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      // Exposure time of the current run, with the warm-up lag taken off.
      function logic [31:0] counted();
         logic [31:0] elapsed;
         if (run_st != ST_RUNNING) return 32'd0;
         elapsed = clk_now - resume_at;
         if (elapsed < {16'd0, lag}) return 32'd0;
         return elapsed - {16'd0, lag};
      endfunction

      function logic [31:0] stop_at();
         return resume_at + remain + {16'd0, lag};
      endfunction

      function void keep_last_run();
         logic [31:0] c;
         c = counted();
         if (c != 0) last_run = c;
      endfunction

      function void halt();
         if (run_st == ST_STOPPED) return;
         beep_on = 1'b0;
         keep_last_run();
         if (run_st == ST_RUNNING) begin
            if (clk_now >= stop_at()) begin
               accum = sat_add(accum, remain);
            end else begin
               accum = sat_add(accum, counted());
            end
         end
         run_st = ST_STOPPED;
         remain = '0;
      endfunction

      function void take_command(logic [2:0] op, logic [31:0] now, logic [31:0] dur);
         rsp_data_type want;
         logic [31:0]  c;
         logic [31:0]  slots;
         logic [31:0]  left_v;
         bit           hit_stop;
         bit           paused_late;
         hit_stop    = 1'b0;
         paused_late = 1'b0;
         case (op)
            OP_TICK: begin
               clk_now = now;
               if (run_st == ST_RUNNING) begin
                  if (clk_now >= stop_at()) begin
                     hit_stop = 1'b1;
                     halt();
                  end else begin
                     keep_last_run();
                     // Beep right after a resume, then on each whole second past the first half.
                     slots   = counted() / BEEP_SLOT_MS;
                     beep_on = ((clk_now - resume_at) <= BEEP_WINDOW_MS) ||
                               (slots > BEEP_MIN_SLOTS && (slots % BEEP_SLOTS_PER_SEC) == 0);
                  end
               end
            end
            OP_START: begin
               remain    = dur;
               resume_at = clk_now;
               run_st    = ST_RUNNING;
            end
            OP_PAUSE: begin
               if (run_st == ST_RUNNING) begin
                  beep_on = 1'b0;
                  keep_last_run();
                  c           = counted();
                  accum       = sat_add(accum, c);
                  remain      = (c > remain) ? 32'd0 : remain - c;
                  paused_late = clk_now > resume_at + {16'd0, lag};
                  run_st      = ST_PAUSED;
               end
            end
            OP_RESUME: begin
               if (run_st == ST_PAUSED) begin
                  resume_at = clk_now;
                  run_st    = ST_RUNNING;
               end
            end
            OP_STOP: begin
               halt();
            end
            OP_RESET: begin
               halt();
               accum    = '0;
               last_run = '0;
            end
            default: begin
            end
         endcase

         c      = counted();
         left_v = (run_st == ST_RUNNING && c != 0) ? stop_at() - clk_now : remain;
         want               = '0;
         want.status        = run_st;
         want.lamp_on       = (run_st == ST_RUNNING);
         want.beep_level    = beep_on ? volume : 8'd0;
         want.just_stopped  = hit_stop;
         want.pause_counted = paused_late;
         want.in_lag        = (run_st == ST_RUNNING && c == 0);
         want.left_ms       = left_v;
         want.total_ms      = sat_add(accum, c);
         want.last_run_ms   = last_run;
         due_results.push_back(want);
         items++;
         if (hit_stop) timeouts++;
         if (want.beep_level != 0) beeps++;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("Mismatch in %s of result %0d: expected %h, got %h",
                        name, results, want, got);
            end
         end
      endfunction

      function void match_result(rsp_data_type got);
         rsp_data_type want;
         results++;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("Result item %0d arrived with none outstanding: %h", results, got);
            end
            return;
         end
         want = due_results.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("lamp_on", 32'(want.lamp_on), 32'(got.lamp_on));
         compare_field("beep_level", 32'(want.beep_level), 32'(got.beep_level));
         compare_field("just_stopped", 32'(want.just_stopped), 32'(got.just_stopped));
         compare_field("pause_counted", 32'(want.pause_counted), 32'(got.pause_counted));
         compare_field("in_lag", 32'(want.in_lag), 32'(got.in_lag));
         compare_field("left_ms", want.left_ms, got.left_ms);
         compare_field("total_ms", want.total_ms, got.total_ms);
         compare_field("last_run_ms", want.last_run_ms, got.last_run_ms);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [15:0]  csr_data;
   logic         req_tvalid;
   logic         req_tready;
   req_data_type req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   rsp_data_type rsp_tdata;

   exposure_tracker tracker = new();
   int              burst_left;
   int              cfg_writes;
   int              random_cmds;
   int              cycle_count;
   logic [31:0]     wall;

   exposure_timer_with_lag_and_beep DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Run hit the cycle limit with %0d results outstanding.",
                  tracker.due_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.match_result(rsp_tdata);
      end
   end

   // The receiver switches between always ready, random stalls and a fixed one-in-four beat.
   initial begin
      int stall_mode;
      int span;
      int beat;
      rsp_tready = 1'b0;
      beat       = 0;
      forever begin
         stall_mode = $urandom_range(0, 2);
         span       = $urandom_range(10, 80);
         repeat (span) begin
            @(negedge clock);
            case (stall_mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 1) == 0);
               default: rsp_tready = (beat % 4 == 0);
            endcase
            beat++;
         end
      end
   end

   // Sends one command item. The valid stays high on return so that bursts run back to back.
   task automatic push_cmd(input logic [2:0] op, input logic [31:0] now, input logic [31:0] dur);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid            = 1'b1;
      req_tuser             = op;
      req_tdata.now_ms      = now;
      req_tdata.duration_ms = dur;
      do @(posedge clock); while (!req_tready);
      tracker.take_command(op, now, dur);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid = 1'b0;
      while (tracker.due_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, value);
      cfg_writes++;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] lag, input logic [7:0] volume);
      hold_until_drained();
      write_reg(CSR_LAG_MS, lag);
      write_reg(CSR_BEEP_VOLUME, {8'd0, volume});
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(50, 4000);
      if (r < 80) return $urandom_range(0, 60);
      if (r < 90) return $urandom_range(4000, 200000);
      if (r < 96) return $urandom;
      return 32'hFFFF_FFFF;
   endfunction

   // One exposure: set the clock, start, then a random mix of ticks and commands.
   task automatic run_session();
      int steps;
      int r;
      wall += $urandom_range(0, 500);
      push_cmd(OP_TICK, wall, $urandom);
      push_cmd(OP_START, $urandom, pick_length());
      random_cmds += 2;
      steps = $urandom_range(4, 30);
      repeat (steps) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               wall += $urandom_range(0, 350);
            end else if (r < 85) begin
               wall += $urandom_range(300, 3000);
            end else if (r < 93) begin
               wall += $urandom_range(0, 80000);
            end else if (r < 96) begin
               wall = $urandom;
            end else begin
               wall -= $urandom_range(1, 1000);
            end
            push_cmd(OP_TICK, wall, $urandom);
            random_cmds++;
         end else if (r < 70) begin
            push_cmd(OP_PAUSE, $urandom, $urandom);
            random_cmds++;
         end else if (r < 80) begin
            push_cmd(OP_RESUME, $urandom, $urandom);
            random_cmds++;
         end else if (r < 85) begin
            push_cmd(OP_STOP, $urandom, $urandom);
            random_cmds++;
         end else if (r < 91) begin
            push_cmd(OP_START, $urandom, pick_length());
            random_cmds++;
         end else if (r < 94) begin
            push_cmd(OP_RESET, $urandom, $urandom);
            random_cmds++;
         end else if (r < 97) begin
            push_cmd(($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom);
         end else begin
            hold_until_drained();
         end
      end
   endtask

   initial begin
      int target;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = 1'b0;
      csr_data    = '0;
      req_tvalid  = 1'b0;
      req_tuser   = '0;
      req_tdata   = '0;
      burst_left  = 0;
      cfg_writes  = 0;
      random_cmds = 0;
      cycle_count = 0;
      wall        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset settings: zero and full lengths, timeouts, wrong-state
      // commands, clock wrap, pause past the remaining time, restart, spare ops, saturation.
      push_cmd(OP_TICK, 32'd0, 32'hFFFF_FFFF);
      push_cmd(OP_START, 32'hFFFF_FFFF, 32'd0);
      push_cmd(OP_TICK, 32'd0, 32'd0);
      push_cmd(OP_START, 32'd0, 32'hFFFF_FFFF);
      push_cmd(OP_TICK, 32'd50, 32'd0);
      push_cmd(OP_TICK, 32'd1050, 32'd0);
      push_cmd(OP_PAUSE, 32'd0, 32'd0);
      push_cmd(OP_PAUSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_cmd(OP_STOP, 32'd0, 32'd0);
      push_cmd(OP_STOP, 32'd0, 32'd0);
      push_cmd(OP_RESUME, 32'd0, 32'd0);
      push_cmd(OP_TICK, 32'hFFFF_FF00, 32'd0);
      push_cmd(OP_START, 32'd0, 32'h50);
      push_cmd(OP_TICK, 32'h10, 32'd0);
      push_cmd(OP_PAUSE, 32'd0, 32'd0);
      push_cmd(OP_RESUME, 32'd0, 32'd0);
      push_cmd(OP_START, 32'd0, 32'd1000);
      push_cmd(OP_TICK, 32'd2000, 32'd0);
      push_cmd(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_cmd(OP_SPARE_B, 32'd0, 32'd0);
      push_cmd(OP_START, 32'd0, 32'hFFFF_FFFF);
      push_cmd(OP_TICK, 32'd1999, 32'd0);
      push_cmd(OP_PAUSE, 32'd0, 32'd0);
      push_cmd(OP_RESET, 32'd0, 32'd0);
      push_cmd(OP_TICK, 32'd0, 32'd0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(16'd0, 8'd255);
            1: set_config(16'hFFFF, 8'd0);
            2: set_config(16'($urandom_range(20, 400)), 8'($urandom));
            3: set_config(16'd1, 8'd1);
            4: set_config(16'($urandom), 8'($urandom));
            default: set_config(16'd150, 8'd128);
         endcase
         target = random_cmds + 60;
         while (random_cmds < target) run_session();
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d commands and %0d results over %0d register writes.",
               tracker.items, tracker.results, cfg_writes);
      $display("Saw %0d timeouts and %0d beeping results; %0d mismatches.",
               tracker.timeouts, tracker.beeps, tracker.errors);
      if (tracker.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
